### hdl/array_list_engine_assert.svh
// Assertion macros shared by the list engine RTL.
`ifndef ARRAY_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ALE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ale check failed: %m");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ALE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ale check failed: %m");

`endif

### hdl/ale_pkg.sv
// Package with the types, codes and sizes of the list engine.
`timescale 1ns / 1ps
package ale_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int IDX_W   = 4;
   localparam int WORD_W  = 32;
   localparam int LEN_W   = 5;
   localparam int POS_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [3:0] {
      CMD_CLEAR     = 4'd0,
      CMD_INS_FIRST = 4'd1,
      CMD_INS_AT    = 4'd2,
      CMD_INS_LAST  = 4'd3,
      CMD_DEL_FIRST = 4'd4,
      CMD_DEL_AT    = 4'd5,
      CMD_DEL_LAST  = 4'd6,
      CMD_SEARCH    = 4'd7,
      CMD_READ      = 4'd8,
      CMD_WRITE     = 4'd9
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_SHIFT_UP,
      OP_SHIFT_DOWN,
      OP_WRITE
   } cell_op_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      cell_op_type        op;
      logic [POS_W-1:0]   pos;
      logic [POS_W-1:0]   count;
      word_type           value;
   } cell_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

### hdl/ale_cell.sv
// One storage cell of the list row: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps
module ale_cell
   import ale_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [POS_W-1:0]   cell_pos,
   input  word_type           left_data,
   input  word_type           right_data,
   output word_type           data,
   output logic               match,
   output word_type           sel_data
);

   word_type data_ff;
   word_type data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         OP_SHIFT_UP: begin
            if (cell_pos > ctl.pos) begin
               data_in = left_data;
            end else if (cell_pos == ctl.pos) begin
               data_in = ctl.value;
            end
         end
         OP_SHIFT_DOWN: begin
            if (cell_pos >= ctl.pos) begin
               data_in = right_data;
            end
         end
         OP_WRITE: begin
            if (cell_pos == ctl.pos) begin
               data_in = ctl.value;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   // Only entries below the length take part in a search.
   assign match    = (cell_pos < ctl.count) && (data_ff == ctl.value);
   assign sel_data = (cell_pos == ctl.pos) ? data_ff : '0;

endmodule

### hdl/ale_row.sv
// Row of list cells chained neighbor to neighbor, with the search and read gathers.
`timescale 1ns / 1ps
module ale_row
   import ale_pkg::*;
(
   input  logic          clock,
   input  cell_ctl_type  ctl,
   output logic          any_match,
   output word_type      sel_word
);

   word_type          cell_data [DEPTH];
   word_type          cell_sel  [DEPTH];
   logic [DEPTH-1:0]  cell_match;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_type left_w;
      word_type right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_data[i+1];
      end

      ale_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_pos   (POS_W'(i)),
         .left_data  (left_w),
         .right_data (right_w),
         .data       (cell_data[i]),
         .match      (cell_match[i]),
         .sel_data   (cell_sel[i])
      );
   end

   assign any_match = |cell_match;

   // At most one cell drives a nonzero word, so an OR gathers the read.
   always_comb begin
      sel_word = '0;
      for (int k = 0; k < DEPTH; k++) begin
         sel_word = sel_word | cell_sel[k];
      end
   end

endmodule

### hdl/array_list_engine.sv
// Top level of the list engine: command intake, status decode, cell row and result register.
`timescale 1ns / 1ps
// The engine keeps a contiguous list of up to DEPTH (16) signed 32-bit words
// in a row of cells, one entry per cell, plus a length count that reset clears.
// Each command transfer on the req_ channel gives exactly one result transfer
// on the rsp_ channel, in order. An insert shifts the later entries up by one
// cell and a delete shifts them down, each cell taking its neighbor's word in
// the same clock, so a command's execution does not depend on the list length.
// A command is captured in the idle state and executed in the execute state,
// which also loads the result register; no new command is taken until the
// previous one has executed. The result register lets the next command be
// taken while the previous result still waits; execution holds only while that
// register is full and not being drained. Failed commands (insert when full,
// delete, read or write when empty, out-of-range index) leave the list as it
// was and report the reason in status. Entries never written read as anything,
// but no command ever reads an entry at or above the length.
module array_list_engine
   import ale_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // [3:0] command, [35:4] value, [39:36] index
   input  logic [39:0]  req_tdata,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [1:0] status, [2] found, [34:3] read_data, [39:35] length
   output logic [39:0]  rsp_tdata
);

`include "array_list_engine_assert.svh"

   state_type            state_ff;
   state_type            state_in;

   cmd_type              cmd_ff;
   word_type             value_ff;
   logic [IDX_W-1:0]     idx_ff;

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   status_type           rsp_status_ff;
   logic                 rsp_found_ff;
   word_type             rsp_data_ff;
   logic [LEN_W-1:0]     rsp_len_ff;

   logic                 req_fire;
   logic                 out_free;
   logic                 exec_go;

   // Decode results for the command held in the capture registers.
   status_type           status_w;
   logic                 found_w;
   word_type             data_w;
   logic [POS_W-1:0]     pos_w;
   logic [POS_W-1:0]     count_w;
   logic [POS_W-1:0]     idx_w;
   cell_op_type          op_w;
   cell_ctl_type         ctl_w;
   logic                 any_match;
   word_type             sel_word;
   logic                 is_full;
   logic                 is_empty;

   // Handshake and sequencing.
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      exec_go    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_EXEC: begin
            exec_go = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Command decode: status, target position and what the cells do.
   assign count_w  = POS_W'(count_ff);
   assign idx_w    = POS_W'(idx_ff);
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   always_comb begin
      status_w = STAT_OK;
      found_w  = 1'b0;
      data_w   = '0;
      pos_w    = idx_w;
      op_w     = OP_HOLD;
      count_in = count_ff;
      case (cmd_ff)
         CMD_CLEAR: begin
            count_in = '0;
         end
         CMD_INS_FIRST, CMD_INS_AT, CMD_INS_LAST: begin
            if (cmd_ff == CMD_INS_FIRST) begin
               pos_w = '0;
            end else if (cmd_ff == CMD_INS_LAST) begin
               pos_w = count_w;
            end
            if (is_full) begin
               status_w = STAT_FULL;
            end else if (pos_w > count_w) begin
               status_w = STAT_RANGE;
            end else begin
               op_w     = OP_SHIFT_UP;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_DEL_FIRST, CMD_DEL_AT, CMD_DEL_LAST: begin
            if (cmd_ff == CMD_DEL_FIRST) begin
               pos_w = '0;
            end else if (cmd_ff == CMD_DEL_LAST) begin
               pos_w = count_w - 1'b1;
            end
            if (is_empty) begin
               status_w = STAT_EMPTY;
            end else if (pos_w >= count_w) begin
               status_w = STAT_RANGE;
            end else begin
               op_w     = OP_SHIFT_DOWN;
               count_in = count_ff - 1'b1;
            end
         end
         CMD_SEARCH: begin
            found_w = any_match;
         end
         CMD_READ, CMD_WRITE: begin
            if (is_empty) begin
               status_w = STAT_EMPTY;
            end else if (idx_w >= count_w) begin
               status_w = STAT_RANGE;
            end else if (cmd_ff == CMD_READ) begin
               data_w = sel_word;
            end else begin
               op_w = OP_WRITE;
            end
         end
         default: begin
            status_w = STAT_OK;
         end
      endcase
   end

   // The cells move only in the cycle that executes the command.
   always_comb begin
      ctl_w.op    = exec_go ? op_w : OP_HOLD;
      ctl_w.pos   = pos_w;
      ctl_w.count = count_w;
      ctl_w.value = value_ff;
   end

   ale_row u_row (
      .clock     (clock),
      .ctl       (ctl_w),
      .any_match (any_match),
      .sel_word  (sel_word)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_go) begin
            count_ff <= count_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= cmd_type'(req_tdata[3:0]);
         value_ff <= req_tdata[35:4];
         idx_ff   <= req_tdata[39:36];
      end
      if (exec_go) begin
         rsp_status_ff <= status_w;
         rsp_found_ff  <= found_w;
         rsp_data_ff   <= data_w;
         rsp_len_ff    <= LEN_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_len_ff, rsp_data_ff, rsp_found_ff, rsp_status_ff};

   // The length never runs past the row.
   `ALE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   // A captured command goes straight to execution.
   `ALE_ASSERT_NEXT(a_fire_to_exec, clock, reset, req_fire, state_ff == ST_EXEC)
   // A failed command leaves the length alone.
   `ALE_ASSERT_NEXT(a_fail_keeps_len, clock, reset, exec_go && (status_w != STAT_OK), $stable(count_ff))
   // Execution never overwrites a result that is still waiting.
   `ALE_ASSERT_IMP(a_no_overrun, clock, reset, exec_go && rsp_valid_ff, rsp_tready)

endmodule
